### sv/dttc_pkg.sv
// ----------------------------------------------------------------------------
// dttc_pkg
// Shared types and constants for the decimal text to cents parser.
// ----------------------------------------------------------------------------
package dttc_pkg;

  localparam int unsigned WHOLE_W = 48;
  localparam int unsigned FRAC_W  = 7;

  // largest integer magnitude that still parses: 10^14
  localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 48'd100000000000000;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_POINT = 8'd46;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef enum logic [2:0] {
    CLS_SPACE = 3'd0,
    CLS_MINUS = 3'd1,
    CLS_POINT = 3'd2,
    CLS_DIGIT = 3'd3,
    CLS_BAD   = 3'd4
  } char_cls_t;

  // one classified character as it sits in the queue
  typedef struct packed {
    char_cls_t   cls;
    logic [3:0]  digit;
    logic        last;
  } char_tok_t;

endpackage

### sv/decimal_text_to_cents.sv
// ----------------------------------------------------------------------------
// decimal_text_to_cents
// Parses a decimal amount text, one character per beat, into signed units
// and hundredths.
// ----------------------------------------------------------------------------
// Input channel: one character per beat (in_char_code), in_last_char set on
// the final character of a string. One result beat comes out per string,
// carried by the beat with in_last_char set; other beats produce nothing.
// Throughput: one character per cycle unless the queue fills while a last
// character waits on a stalled result; the parse step (multiply-by-ten add
// and limit compare on the 48-bit accumulator) is combinational logic.
// The result of a last character passes through the token queue, then loads
// the result register once that register is free.
// A classifier feeds a two-entry queue; the parse engine drains it and loads
// a single result register. Characters keep flowing while a result waits;
// only a following last character waits for the result register to free up.
// in_stall rises when the queue is full. While out_stall is high the result
// holds steady. Synchronous reset empties the queue, drops any pending result
// and puts the parser back at the start of a string.
// ----------------------------------------------------------------------------
module decimal_text_to_cents
  import dttc_pkg::*;
#(
  parameter int unsigned MAX_CHARS  = 15,
  parameter int unsigned MAX_SPACES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_valid_res,
  output logic signed [47:0] out_integer_part,
  output logic signed [7:0]  out_hundredths,
  output logic               out_was_rounded
);

  char_tok_t          in_tok;
  char_tok_t          head_tok;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_head_valid;
  logic [WHOLE_W-1:0] res_mag;
  logic [FRAC_W-1:0]  res_frac;
  logic               res_neg;

  assign q_push   = in_valid && !q_full;
  assign in_stall = q_full;

  dttc_front u_front (
    .char_code (in_char_code),
    .last_char (in_last_char),
    .tok       (in_tok)
  );

  dttc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (in_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_tok   (head_tok)
  );

  dttc_back #(
    .MAX_CHARS  (MAX_CHARS),
    .MAX_SPACES (MAX_SPACES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_tok   (head_tok),
    .pop        (q_pop),
    .res_stall  (out_stall),
    .res_valid  (out_valid),
    .res_ok     (out_valid_res),
    .res_mag    (res_mag),
    .res_frac   (res_frac),
    .res_neg    (res_neg),
    .res_rnd    (out_was_rounded)
  );

  // sign applied on the way out of the result register
  assign out_integer_part = res_neg ? -$signed(res_mag) : $signed(res_mag);
  assign out_hundredths   = res_neg ? -$signed({1'b0, res_frac}) : $signed({1'b0, res_frac});

endmodule

### sv/dttc_front.sv
// ----------------------------------------------------------------------------
// dttc_front
// Classifies an incoming character into a token for the back end.
// ----------------------------------------------------------------------------
module dttc_front
  import dttc_pkg::*;
(
  input  logic [7:0] char_code,
  input  logic       last_char,
  output char_tok_t  tok
);

  always_comb begin
    tok.last  = last_char;
    // low nibble of an ASCII digit is its value
    tok.digit = char_code[3:0];
    priority if (char_code == CHAR_SPACE ||
                 (char_code >= CHAR_TAB && char_code <= CHAR_CR)) begin
      tok.cls = CLS_SPACE;
    end else if (char_code == CHAR_MINUS) begin
      tok.cls = CLS_MINUS;
    end else if (char_code == CHAR_POINT) begin
      tok.cls = CLS_POINT;
    end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
      tok.cls = CLS_DIGIT;
    end else begin
      tok.cls = CLS_BAD;
    end
  end

endmodule

### sv/dttc_queue.sv
// ----------------------------------------------------------------------------
// dttc_queue
// Two-entry token queue between front and back end.
// ----------------------------------------------------------------------------
module dttc_queue
  import dttc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  char_tok_t push_tok,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output char_tok_t head_tok
);

  char_tok_t   mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

### sv/dttc_back.sv
// ----------------------------------------------------------------------------
// dttc_back
// Parse state machine and accumulators; loads the result register on the
// flagged last character.
// ----------------------------------------------------------------------------
module dttc_back
  import dttc_pkg::*;
#(
  parameter int unsigned MAX_CHARS  = 15,
  parameter int unsigned MAX_SPACES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  char_tok_t          head_tok,
  output logic               pop,
  input  logic               res_stall,
  output logic               res_valid,
  output logic               res_ok,
  output logic [WHOLE_W-1:0] res_mag,
  output logic [FRAC_W-1:0]  res_frac,
  output logic               res_neg,
  output logic               res_rnd
);

  localparam int unsigned CCW = $clog2(MAX_CHARS + 1);
  localparam int unsigned SCW = $clog2(MAX_SPACES + 1);
  localparam int unsigned EXW = WHOLE_W + 4;

  typedef enum logic [2:0] {
    PH_SPACE = 3'b001,
    PH_BODY  = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [SCW-1:0]     sc_r, sc_nxt;
  logic [CCW-1:0]     cc_r, cc_nxt;
  logic               neg_r, neg_nxt;
  logic               pt_r, pt_nxt;
  logic [1:0]         fd_r, fd_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic               err_r, err_nxt;
  logic               rnd_r, rnd_nxt;

  logic               out_v_r, out_v_nxt;
  logic               out_ok_r;
  logic [WHOLE_W-1:0] out_mag_r;
  logic [FRAC_W-1:0]  out_frac_r;
  logic               out_neg_r;
  logic               out_rnd_r;

  logic               out_free;
  logic               load;
  logic               ok;
  logic [CCW-1:0]     cc_inc;
  logic [EXW-1:0]     whole_ext;
  logic [EXW-1:0]     whole_x10;

  // values after this beat's update, before the end-of-string clear
  logic [WHOLE_W-1:0] whole_upd;
  logic [FRAC_W-1:0]  frac_upd;
  logic               neg_upd;
  logic               rnd_upd;

  assign out_free = !out_v_r || !res_stall;
  assign pop      = head_valid && (!head_tok.last || out_free);
  assign load     = pop && head_tok.last;

  assign whole_ext = {4'd0, whole_r};
  assign whole_x10 = (whole_ext << 3) + (whole_ext << 1) + {{(EXW-4){1'b0}}, head_tok.digit};
  assign cc_inc    = (cc_r < CCW'(MAX_CHARS)) ? cc_r + CCW'(1) : cc_r;

  always_comb begin
    phase_nxt = phase_r;
    sc_nxt    = sc_r;
    cc_nxt    = cc_r;
    neg_nxt   = neg_r;
    pt_nxt    = pt_r;
    fd_nxt    = fd_r;
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    err_nxt   = err_r;
    rnd_nxt   = rnd_r;
    if (pop && !err_r) begin
      if (phase_r == PH_SPACE && head_tok.cls == CLS_SPACE) begin
        if (sc_r >= SCW'(MAX_SPACES)) begin
          err_nxt = 1'b1;
        end else begin
          sc_nxt = sc_r + SCW'(1);
        end
      end else begin
        cc_nxt = cc_inc;
        if (cc_inc >= CCW'(MAX_CHARS)) begin
          err_nxt = 1'b1;
        end else if (head_tok.cls == CLS_MINUS) begin
          if (phase_r != PH_SPACE) begin
            err_nxt = 1'b1;
          end else begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_BODY;
          end
        end else begin
          if (phase_r == PH_SPACE) begin
            phase_nxt = PH_BODY;
          end
          unique case (head_tok.cls)
            CLS_POINT: begin
              if (pt_r) begin
                err_nxt = 1'b1;
              end else begin
                pt_nxt = 1'b1;
              end
            end
            CLS_DIGIT: begin
              phase_nxt = PH_DIGIT;
              if (!pt_r) begin
                if (whole_x10 > {4'd0, WHOLE_LIMIT}) begin
                  err_nxt = 1'b1;
                end else begin
                  whole_nxt = whole_x10[WHOLE_W-1:0];
                end
              end else begin
                unique case (fd_r)
                  2'd0: begin
                    frac_nxt = {head_tok.digit, 3'b000} + {2'b00, head_tok.digit, 1'b0};
                    fd_nxt   = 2'd1;
                  end
                  2'd1: begin
                    frac_nxt = frac_r + {3'b000, head_tok.digit};
                    fd_nxt   = 2'd2;
                  end
                  2'd2: begin
                    fd_nxt  = 2'd3;
                    rnd_nxt = 1'b1;
                    if (head_tok.digit >= 4'd5) begin
                      if (frac_r == 7'd99) begin
                        frac_nxt = '0;
                        // carry into the whole part
                        if (whole_r == WHOLE_LIMIT) begin
                          err_nxt = 1'b1;
                        end else begin
                          whole_nxt = whole_r + WHOLE_W'(1);
                        end
                      end else begin
                        frac_nxt = frac_r + 7'd1;
                      end
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end
    end
    ok        = !err_nxt && (phase_nxt == PH_DIGIT);
    whole_upd = whole_nxt;
    frac_upd  = frac_nxt;
    neg_upd   = neg_nxt;
    rnd_upd   = rnd_nxt;
    if (load) begin
      phase_nxt = PH_SPACE;
      sc_nxt    = '0;
      cc_nxt    = '0;
      neg_nxt   = 1'b0;
      pt_nxt    = 1'b0;
      fd_nxt    = 2'd0;
      whole_nxt = '0;
      frac_nxt  = '0;
      err_nxt   = 1'b0;
      rnd_nxt   = 1'b0;
    end
    out_v_nxt = load ? 1'b1 : (out_v_r && res_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      sc_r    <= '0;
      cc_r    <= '0;
      neg_r   <= 1'b0;
      pt_r    <= 1'b0;
      fd_r    <= 2'd0;
      whole_r <= '0;
      frac_r  <= '0;
      err_r   <= 1'b0;
      rnd_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sc_r    <= sc_nxt;
      cc_r    <= cc_nxt;
      neg_r   <= neg_nxt;
      pt_r    <= pt_nxt;
      fd_r    <= fd_nxt;
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      err_r   <= err_nxt;
      rnd_r   <= rnd_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // result payload, zeroed for a failed parse
  always_ff @(posedge clk) begin
    if (load) begin
      out_ok_r   <= ok;
      out_mag_r  <= ok ? whole_upd : '0;
      out_frac_r <= ok ? frac_upd : '0;
      out_neg_r  <= ok && neg_upd;
      out_rnd_r  <= ok && rnd_upd;
    end
  end

  assign res_valid = out_v_r;
  assign res_ok    = out_ok_r;
  assign res_mag   = out_mag_r;
  assign res_frac  = out_frac_r;
  assign res_neg   = out_neg_r;
  assign res_rnd   = out_rnd_r;

endmodule

### sv/dttc_checker.sv
// ----------------------------------------------------------------------------
// dttc_checker
// Port-level checks on the result channel of decimal_text_to_cents.
// ----------------------------------------------------------------------------
module dttc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_valid_res,
  input logic signed [47:0] out_integer_part,
  input logic signed [7:0]  out_hundredths,
  input logic               out_was_rounded
);

  // a stalled result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_integer_part) &&
      $stable(out_hundredths) && $stable(out_valid_res))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_integer_part == 48'sd0 && out_hundredths == 8'sd0 && !out_was_rounded)
    else $error("failed parse carries a nonzero payload");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hundredths >= -8'sd99 && out_hundredths <= 8'sd99)
    else $error("hundredths out of range");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_integer_part < 48'sd0 |-> out_hundredths <= 8'sd0)
    else $error("hundredths sign disagrees with integer part");

endmodule

bind decimal_text_to_cents dttc_checker u_dttc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_valid_res    (out_valid_res),
  .out_integer_part (out_integer_part),
  .out_hundredths   (out_hundredths),
  .out_was_rounded  (out_was_rounded)
);

### bench/decimal_text_to_cents_tb.sv
// ----------------------------------------------------------------------------
// decimal_text_to_cents_tb
// Checks the amount parser against a cycle-free prediction of each string.
// A driver feeds characters from a queue with random gaps, a monitor applies
// random output stalls and compares every result beat with the oldest
// predicted amount. A short directed set of strings comes first, followed
// by random amounts, most of them well formed, some broken, some noise.
// ----------------------------------------------------------------------------
module decimal_text_to_cents_tb
  import dttc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CHARS   = 15;
  localparam int unsigned MAX_SPACES  = 10;
  localparam int          RAND_CHARS  = 1100;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          CALM_TAIL   = 200;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_OPEN   = 2'd1,
    PH_DIGITS = 2'd2
  } parse_phase_t;

  typedef struct {
    parse_phase_t phase;
    int unsigned  spaces;
    int unsigned  body_len;
    bit           neg;
    bit           point;
    int unsigned  frac_cnt;
    logic [63:0]  whole;
    int unsigned  frac;
    bit           err;
    bit           rnd;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [47:0] units;
    logic [7:0]  cents;
    logic        rnd;
  } amount_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
    bit         hold;
  } char_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code = 8'd0;
  logic               in_last_char = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_valid_res;
  logic signed [47:0] out_integer_part;
  logic signed [7:0]  out_hundredths;
  logic               out_was_rounded;

  char_beat_t   text_q[$];
  amount_t      amount_q[$];
  logic [7:0]   text_buf[$];
  parse_state_t pst;

  int cyc = 0;
  int fail_cnt = 0;
  int n_chars = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_ok = 0;
  int n_rnd = 0;
  int gap_left = 0;
  int stall_left = 0;

  decimal_text_to_cents #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_SPACES(MAX_SPACES)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_valid_res   (out_valid_res),
    .out_integer_part(out_integer_part),
    .out_hundredths  (out_hundredths),
    .out_was_rounded (out_was_rounded)
  );

  always #2 clk = ~clk;

  function automatic parse_state_t fresh_state();
    parse_state_t s;
    s.phase    = PH_LEAD;
    s.spaces   = 0;
    s.body_len = 0;
    s.neg      = 1'b0;
    s.point    = 1'b0;
    s.frac_cnt = 0;
    s.whole    = '0;
    s.frac     = 0;
    s.err      = 1'b0;
    s.rnd      = 1'b0;
    return s;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // advance the parse by one character; returns 1 when an amount is due
  function automatic bit parse_char(input logic [7:0] c, input logic last,
                                    output amount_t res);
    logic [63:0] v;
    int unsigned d;
    res = '0;
    if (!pst.err) begin
      if (pst.phase == PH_LEAD && is_blank(c)) begin
        if (pst.spaces >= MAX_SPACES) pst.err = 1'b1;
        else pst.spaces++;
      end else begin
        if (pst.body_len < MAX_CHARS) pst.body_len++;
        if (pst.body_len >= MAX_CHARS) begin
          pst.err = 1'b1;
        end else if (c == CHAR_MINUS) begin
          if (pst.phase != PH_LEAD) pst.err = 1'b1;
          else begin
            pst.neg   = 1'b1;
            pst.phase = PH_OPEN;
          end
        end else begin
          if (pst.phase == PH_LEAD) pst.phase = PH_OPEN;
          if (c == CHAR_POINT) begin
            if (pst.point) pst.err = 1'b1;
            else pst.point = 1'b1;
          end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
            pst.err = 1'b1;
          end else begin
            d = c - CHAR_ZERO;
            pst.phase = PH_DIGITS;
            if (!pst.point) begin
              v = pst.whole * 10 + d;
              if (v > WHOLE_LIMIT) pst.err = 1'b1;
              else pst.whole = v;
            end else if (pst.frac_cnt == 0) begin
              pst.frac     = d * 10;
              pst.frac_cnt = 1;
            end else if (pst.frac_cnt == 1) begin
              pst.frac     = pst.frac + d;
              pst.frac_cnt = 2;
            end else if (pst.frac_cnt == 2) begin
              // third digit rounds half up, later ones are dropped
              pst.frac_cnt = 3;
              pst.rnd      = 1'b1;
              if (d >= 5) begin
                pst.frac++;
                if (pst.frac >= 100) begin
                  pst.frac = 0;
                  if (pst.whole + 1 > WHOLE_LIMIT) pst.err = 1'b1;
                  else pst.whole = pst.whole + 1;
                end
              end
            end
          end
        end
      end
    end
    if (!last) return 1'b0;
    if (!pst.err && pst.phase == PH_DIGITS) begin
      res.ok    = 1'b1;
      res.units = pst.neg ? -pst.whole[47:0] : pst.whole[47:0];
      res.cents = pst.neg ? 8'(-pst.frac) : 8'(pst.frac);
      res.rnd   = pst.rnd;
    end
    pst = fresh_state();
    return 1'b1;
  endfunction

  function automatic bit idle_allowed();
    return text_q.size() > CALM_TAIL && cyc[8:7] != 2'b00;
  endfunction

  task automatic flush_text(input bit hold);
    foreach (text_buf[i]) begin
      text_q.push_back('{code: text_buf[i], last: (i == text_buf.size() - 1),
                         hold: (hold && i == 0)});
    end
    text_buf.delete();
    n_strings++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    flush_text(1'b0);
  endtask

  task automatic push_digits(input int n, input bit lean_nine);
    for (int i = 0; i < n; i++) begin
      if (lean_nine && $urandom_range(0, 1) == 0) text_buf.push_back(CHAR_NINE);
      else text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic make_amount(input bit hold);
    int kind;
    int pos;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2)) begin
        if ($urandom_range(0, 1) == 0) text_buf.push_back(CHAR_SPACE);
        else text_buf.push_back(CHAR_TAB + 8'($urandom_range(0, 4)));
      end
      if ($urandom_range(0, 2) == 0) text_buf.push_back(CHAR_MINUS);
      push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6),
                  $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        text_buf.push_back(CHAR_POINT);
        push_digits($urandom_range(0, 5), $urandom_range(0, 1) == 0);
      end
      if (kind == 1 && text_buf.size() != 0) begin
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: text_buf[pos] = 8'($urandom_range(0, 255));
          1: text_buf.insert(pos, CHAR_POINT);
          2: text_buf.insert(pos, CHAR_MINUS);
          default: text_buf.insert(pos, CHAR_SPACE);
        endcase
      end
    end
    if (text_buf.size() == 0) text_buf.push_back(CHAR_ZERO);
    flush_text(hold);
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("result %0d: %s mismatch, expected %0h, got %0h",
               n_results, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d amounts outstanding", cyc, amount_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // driver: one character per beat, random gaps, hold-off before marked strings
  always @(posedge clk) begin : drive_p
    char_beat_t nx;
    amount_t    res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_char(in_char_code, in_last_char, res)) amount_q.push_back(res);
        n_chars++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_q.size() != 0 && !(text_q[0].hold && amount_q.size() != 0)) begin
          nx = text_q.pop_front();
          in_char_code <= nx.code;
          in_last_char <= nx.last;
          in_valid     <= 1'b1;
          if (idle_allowed() && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall bursts, compare each result beat with the oldest amount
  always @(posedge clk) begin : watch_p
    amount_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (amount_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result %0d arrived with no amount pending", n_results);
        end else begin
          want = amount_q.pop_front();
          if (want.ok) n_ok++;
          if (want.rnd) n_rnd++;
          if (out_valid_res !== want.ok)
            note_mismatch("valid_res", 64'(want.ok), 64'(out_valid_res));
          if (out_integer_part !== want.units)
            note_mismatch("integer_part", 64'(want.units), 64'(out_integer_part));
          if (out_hundredths !== want.cents)
            note_mismatch("hundredths", 64'(want.cents), 64'(out_hundredths));
          if (out_was_rounded !== want.rnd)
            note_mismatch("was_rounded", 64'(want.rnd), 64'(out_was_rounded));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stim_p
    int queued;
    int idx;
    pst = fresh_state();

    // directed strings
    add_text("0");
    add_text("-9.5");
    add_text(" \t12.345");
    add_text("9.995");
    add_text("-1.23999");
    add_text("0.07");
    add_text("1.2.3");
    add_text("1-");
    add_text("-");
    add_text(".");
    add_text("-.");
    add_text(" 1 ");
    add_text("          1");
    add_text("           1");
    add_text("12345678901234");
    add_text("123456789012345");
    text_buf.push_back(8'h00);
    flush_text(1'b0);
    text_buf.push_back(CHAR_ZERO + 8'd7);
    text_buf.push_back(8'hFF);
    flush_text(1'b0);

    // random amounts; a few strings wait for the output to drain first
    queued = text_q.size();
    idx = 0;
    while (text_q.size() < queued + RAND_CHARS) begin
      make_amount(idx == 40 || idx == 100);
      idx++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid) @(posedge clk);
    while (amount_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (amount_q.size() != 0) begin
      fail_cnt += amount_q.size();
      $display("%0d amounts never arrived", amount_q.size());
    end
    $display("Fed %0d characters in %0d strings; checked %0d results", n_chars, n_strings,
             n_results);
    $display("  %0d parsed, %0d rejected, %0d rounded; %0d failures", n_ok,
             n_results - n_ok, n_rnd, fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
